>>> rtl/arn_pkg.sv
// Shared types, widths and constants for the adaptive rate neuron step block.
// No dependencies; imported by every module of the block.
package arn_pkg;

  // Fixed-point formats
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DECAY_W    = 16;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DECAY_BITS = 16;

  // Register file
  localparam int unsigned CFG_IDX_W  = 3;

  // Digit-serial multiplier geometry
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIGITS     = 9;
  localparam int unsigned MUL_A_W    = DATA_W + 2;
  localparam int unsigned MUL_B_W    = DIGIT_W * DIGITS;
  localparam int unsigned MUL_ACC_W  = MUL_A_W + DIGIT_W + 1;
  localparam int unsigned PROD_W     = MUL_ACC_W + MUL_B_W;
  localparam int unsigned DCNT_W     = $clog2(DIGITS);

  // Register reset values
  localparam logic [DECAY_W-1:0] RST_MDECAY = DECAY_W'(62000);
  localparam logic [DATA_W-1:0]  RST_GAIN   = DATA_W'(655);
  localparam logic [DATA_W-1:0]  RST_WEXC   = DATA_W'(32768000);
  localparam logic [DATA_W-1:0]  RST_BIAS   = DATA_W'(0);
  localparam logic [DECAY_W-1:0] RST_ADECAY = DECAY_W'(59300);
  localparam logic [DATA_W-1:0]  RST_ASTEP  = DATA_W'(400031744);
  localparam logic [DATA_W-1:0]  RST_THR    = DATA_W'(11796);
  localparam logic [DECAY_W-1:0] RST_RDECAY = DECAY_W'(63380);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_MDECAY = 3'd0,
    IDX_GAIN   = 3'd1,
    IDX_WEXC   = 3'd2,
    IDX_BIAS   = 3'd3,
    IDX_ADECAY = 3'd4,
    IDX_ASTEP  = 3'd5,
    IDX_THR    = 3'd6,
    IDX_RDECAY = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [DECAY_W-1:0] mdecay;
    logic [DATA_W-1:0]  gain;
    logic [DATA_W-1:0]  wexc;
    logic [DATA_W-1:0]  bias;
    logic [DECAY_W-1:0] adecay;
    logic [DATA_W-1:0]  astep;
    logic [DATA_W-1:0]  thr;
    logic [DECAY_W-1:0] rdecay;
  } cfg_t;

  // Multiplier request and response
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  // Sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_WEXC,
    OP_GAIN,
    OP_MEM,
    OP_ADAPT,
    OP_RATE
  } op_t;

endpackage

>>> rtl/arn_cfg_regs.sv
// Configuration register file for the neuron step block.
// Depends on arn_pkg for the register layout and reset values.
module arn_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [arn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arn_pkg::DATA_W-1:0]   cfg_wdata,
  output arn_pkg::cfg_t                cfg
);
  import arn_pkg::*;

  cfg_t cfg_r;

  // Write the addressed register, load reset values on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mdecay <= RST_MDECAY;
      cfg_r.gain   <= RST_GAIN;
      cfg_r.wexc   <= RST_WEXC;
      cfg_r.bias   <= RST_BIAS;
      cfg_r.adecay <= RST_ADECAY;
      cfg_r.astep  <= RST_ASTEP;
      cfg_r.thr    <= RST_THR;
      cfg_r.rdecay <= RST_RDECAY;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        IDX_MDECAY: cfg_r.mdecay <= cfg_wdata[DECAY_W-1:0];
        IDX_GAIN:   cfg_r.gain   <= cfg_wdata;
        IDX_WEXC:   cfg_r.wexc   <= cfg_wdata;
        IDX_BIAS:   cfg_r.bias   <= cfg_wdata;
        IDX_ADECAY: cfg_r.adecay <= cfg_wdata[DECAY_W-1:0];
        IDX_ASTEP:  cfg_r.astep  <= cfg_wdata;
        IDX_THR:    cfg_r.thr    <= cfg_wdata;
        IDX_RDECAY: cfg_r.rdecay <= cfg_wdata[DECAY_W-1:0];
        default:    cfg_r.thr    <= cfg_r.thr;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/arn_serial_mul.sv
// Digit-serial signed multiplier: one 4-bit digit of the multiplier per cycle.
// Depends on arn_pkg for widths and the request/response structs.
module arn_serial_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  arn_pkg::mul_req_t req,
  output arn_pkg::mul_rsp_t rsp
);
  import arn_pkg::*;

  logic [MUL_A_W-1:0]          a_r;
  logic [MUL_B_W-1:0]          b_r;
  logic signed [MUL_ACC_W-1:0] acc_r;
  logic [MUL_B_W-1:0]          low_r;
  logic [DCNT_W-1:0]           cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic                        last_digit;
  logic [DIGIT_W:0]            digit;
  logic signed [MUL_ACC_W-1:0] a_ext;
  logic signed [MUL_ACC_W-1:0] d_ext;
  logic signed [MUL_ACC_W-1:0] pp;
  logic signed [MUL_ACC_W-1:0] sum;

  // Form one partial product; the top digit carries the sign
  always_comb begin
    last_digit = (cnt_r == DCNT_W'(DIGITS - 1));
    digit      = {last_digit & b_r[DIGIT_W-1], b_r[DIGIT_W-1:0]};
    a_ext      = {{(MUL_ACC_W - MUL_A_W){a_r[MUL_A_W-1]}}, a_r};
    d_ext      = {{(MUL_ACC_W - DIGIT_W - 1){digit[DIGIT_W]}}, digit};
    pp         = a_ext * d_ext;
    sum        = acc_r + pp;
  end

  // Control: count digits, flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r & last_digit;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        busy_r <= ~last_digit;
        cnt_r  <= cnt_r + DCNT_W'(1);
      end
    end
  end

  // Datapath: accumulate, shift retired digits into the low word
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
      low_r <= '0;
    end else if (busy_r) begin
      b_r   <= b_r >> DIGIT_W;
      acc_r <= sum >>> DIGIT_W;
      low_r <= {sum[DIGIT_W-1:0], low_r[MUL_B_W-1:DIGIT_W]};
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = {acc_r, low_r};

endmodule

>>> rtl/adaptive_rate_neuron_step_top.sv
// Adaptive rate neuron step: one tick per request, five products on one
// shared digit-serial multiplier, each issued once the one before is done.
// The block takes no new request until the last result is in the output
// register, where results wait. Synchronous active-low reset clears membrane,
// adaptation and rate estimate to zero and loads the register reset values.
module adaptive_rate_neuron_step_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [arn_pkg::DATA_W-1:0]    in_exc_drive,
  input  logic [arn_pkg::DATA_W-1:0]    in_inh_drive,
  input  logic [arn_pkg::DATA_W-1:0]    in_noise_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_fired,
  output logic [arn_pkg::DATA_W-1:0]    out_rate_signal,
  output logic [arn_pkg::DATA_W-1:0]    out_membrane_out,
  input  logic                          cfg_we,
  input  logic [arn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arn_pkg::DATA_W-1:0]    cfg_wdata
);
  import arn_pkg::*;

  localparam int unsigned SUM_W = DATA_W + 3;
  localparam int unsigned DIF_W = DATA_W + 2;
  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] HALF_D = PROD_W'(64'd1 << (DECAY_BITS - 1));

  cfg_t     cfg;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [DATA_W-1:0] exc_r, inh_r, noise_r;
  logic [DATA_W-1:0] t_r, cur_r;
  logic [DATA_W-1:0] mem_r, adapt_r, rate_r;
  logic              fired_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_fired_r;
  logic [DATA_W-1:0] out_rate_r, out_mem_r;

  logic                     accept;
  logic                     out_load;
  logic signed [SUM_W-1:0]  cur_sum;
  logic [DATA_W-1:0]        cur_sat;
  logic [DATA_W-1:0]        adapt_tgt;
  logic [DATA_W-1:0]        rate_tgt;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd_q;
  logic signed [PROD_W-1:0] rnd_d;
  logic [DATA_W-1:0]        rnd_q_sat;
  logic [DATA_W-1:0]        mem_new;
  logic signed [DIF_W-1:0]  fire_dif;
  logic                     fire_new;
  logic [DATA_W-1:0]        rate_neg;

  // Saturate a wide signed value to 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(S32_MAX);
    lo = PROD_W'(S32_MIN);
    if (v > hi)      sat32 = S32_MAX;
    else if (v < lo) sat32 = S32_MIN;
    else             sat32 = v[DATA_W-1:0];
  endfunction

  arn_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  arn_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // Handshakes
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign out_load = (state_r == ST_DONE) & (~out_valid_r | ~out_stall);

  // Operands for each product step
  always_comb begin
    cur_sum   = SUM_W'($signed(t_r)) + SUM_W'($signed(inh_r))
              + SUM_W'($signed(noise_r)) + SUM_W'($signed(cfg.bias));
    cur_sat   = sat32(PROD_W'(cur_sum));
    adapt_tgt = fired_r ? cfg.astep : '0;
    rate_tgt  = fired_r ? ONE_Q : '0;

    mreq.start = (state_r == ST_ISSUE);
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (op_r)
      OP_WEXC: begin
        mreq.a = MUL_A_W'($signed(exc_r));
        mreq.b = MUL_B_W'($signed(cfg.wexc));
      end
      OP_GAIN: begin
        mreq.a = MUL_A_W'($signed(cur_sat));
        mreq.b = MUL_B_W'($signed(cfg.gain));
      end
      OP_MEM: begin
        mreq.a = MUL_A_W'($signed(mem_r)) - MUL_A_W'($signed(cur_r));
        mreq.b = MUL_B_W'(cfg.mdecay);
      end
      OP_ADAPT: begin
        mreq.a = MUL_A_W'($signed(adapt_r)) - MUL_A_W'($signed(adapt_tgt));
        mreq.b = MUL_B_W'(cfg.adecay);
      end
      OP_RATE: begin
        mreq.a = MUL_A_W'($signed(rate_r)) - MUL_A_W'($signed(rate_tgt));
        mreq.b = MUL_B_W'(cfg.rdecay);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  // Round the finished product; blends add the target back on
  always_comb begin
    prod      = $signed(mrsp.product);
    rnd_q     = (prod + HALF_Q) >>> FRAC_BITS;
    rnd_d     = (prod + HALF_D) >>> DECAY_BITS;
    rnd_q_sat = sat32(rnd_q);
    mem_new   = cur_r + rnd_d[DATA_W-1:0];
    fire_dif  = DIF_W'($signed(mem_new)) - DIF_W'($signed(adapt_r));
    fire_new  = (fire_dif >= DIF_W'($signed(cfg.thr)));
    rate_neg  = ($signed(rate_r) == S32_MIN) ? S32_MAX : DATA_W'(-$signed(rate_r));
  end

  // Sequencer: issue each product, wait, then move to the next step
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ISSUE;
          op_nxt    = OP_WEXC;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mrsp.done) begin
          unique case (op_r)
            OP_WEXC:  begin op_nxt = OP_GAIN;  state_nxt = ST_ISSUE; end
            OP_GAIN:  begin op_nxt = OP_MEM;   state_nxt = ST_ISSUE; end
            OP_MEM:   begin op_nxt = OP_ADAPT; state_nxt = ST_ISSUE; end
            OP_ADAPT: begin op_nxt = OP_RATE;  state_nxt = ST_ISSUE; end
            default:  begin op_nxt = OP_WEXC;  state_nxt = ST_DONE;  end
          endcase
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_WEXC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Neuron state: cleared on reset, advanced as each step completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r   <= '0;
      adapt_r <= '0;
      rate_r  <= '0;
      fired_r <= 1'b0;
    end else if (state_r == ST_WAIT && mrsp.done) begin
      unique case (op_r)
        OP_MEM: begin
          mem_r   <= mem_new;
          fired_r <= fire_new;
        end
        OP_ADAPT: adapt_r <= adapt_tgt + rnd_d[DATA_W-1:0];
        OP_RATE:  rate_r  <= rate_tgt + rnd_d[DATA_W-1:0];
        default:  fired_r <= fired_r;
      endcase
    end
  end

  // Request capture and intermediate currents
  always_ff @(posedge clk) begin
    if (accept) begin
      exc_r   <= in_exc_drive;
      inh_r   <= in_inh_drive;
      noise_r <= in_noise_sample;
    end
    if (state_r == ST_WAIT && mrsp.done) begin
      if (op_r == OP_WEXC) t_r   <= rnd_q_sat;
      if (op_r == OP_GAIN) cur_r <= rnd_q_sat;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fired_r <= fired_r;
      out_rate_r  <= fired_r ? rate_r : rate_neg;
      out_mem_r   <= mem_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fired        = out_fired_r;
  assign out_rate_signal  = out_rate_r;
  assign out_membrane_out = out_mem_r;

endmodule

>>> dv/tb.sv
// Self-checking testbench for adaptive_rate_neuron_step_top: a clocked driver
// and monitor around a tick-level predictor of the neuron's fixed-point update.
// Depends on rtl/arn_pkg.sv and rtl/adaptive_rate_neuron_step_top.sv.
`timescale 1ns / 1ps

module tb;
  import arn_pkg::*;

  localparam int FRAC_W      = FRAC_BITS;
  localparam int DEC_W       = DECAY_BITS;
  localparam int WDOG_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int SEG_ITEMS   = 313;
  localparam int DRAIN_WAIT  = 60;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] exc;
    logic [DATA_W-1:0] inh;
    logic [DATA_W-1:0] noise;
  } tick_input_t;

  typedef struct packed {
    logic              fired;
    logic [DATA_W-1:0] rate;
    logic [DATA_W-1:0] mem;
  } tick_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_exc_drive = '0;
  logic [DATA_W-1:0]    in_inh_drive = '0;
  logic [DATA_W-1:0]    in_noise_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_fired;
  logic [DATA_W-1:0]    out_rate_signal;
  logic [DATA_W-1:0]    out_membrane_out;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = IDX_MDECAY;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  // Predictor copy of the register file and the neuron state
  longint cfg_mdecay, cfg_gain, cfg_wexc, cfg_bias;
  longint cfg_adecay, cfg_astep, cfg_thr, cfg_rdecay;
  longint nrn_membrane, nrn_adaptation, nrn_rate;

  tick_input_t  pending_ticks[$];
  tick_result_t expected_ticks[$];

  int  errors = 0;
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  pressure_armed = 1'b0;
  bit  pressure_done = 1'b0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;

  adaptive_rate_neuron_step_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_exc_drive     (in_exc_drive),
    .in_inh_drive     (in_inh_drive),
    .in_noise_sample  (in_noise_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired        (out_fired),
    .out_rate_signal  (out_rate_signal),
    .out_membrane_out (out_membrane_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------
  function automatic longint sat32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return -longint'(32'sh7FFF_FFFF) - 1;
    return v;
  endfunction

  function automatic longint sx32(logic [DATA_W-1:0] v);
    return longint'(signed'(v));
  endfunction

  // Round half up, then saturate
  function automatic longint mul_q(longint a, longint b);
    return sat32((a * b + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W);
  endfunction

  // Decay blend d*x + (1-d)*y with a Q0.16 factor
  function automatic longint decay_blend(longint d, longint x, longint y);
    longint one;
    one = longint'(1) <<< DEC_W;
    return sat32((d * x + (one - d) * y + (one >>> 1)) >>> DEC_W);
  endfunction

  // Advance the neuron one tick and return the result it gives
  function automatic tick_result_t neuron_tick(tick_input_t t);
    longint       total, cur, rs;
    logic         fire;
    tick_result_t r;
    total = sat32(mul_q(cfg_wexc, sx32(t.exc)) + sx32(t.inh) + sx32(t.noise) + cfg_bias);
    cur = mul_q(cfg_gain, total);
    nrn_membrane = decay_blend(cfg_mdecay, nrn_membrane, cur);
    // exact compare, no wrap on the difference
    fire = (nrn_membrane - nrn_adaptation) >= cfg_thr;
    nrn_adaptation = decay_blend(cfg_adecay, nrn_adaptation, fire ? cfg_astep : 0);
    nrn_rate = decay_blend(cfg_rdecay, nrn_rate, fire ? (longint'(1) <<< FRAC_W) : 0);
    rs = fire ? nrn_rate : sat32(-nrn_rate);
    r.fired = fire;
    r.rate  = rs[DATA_W-1:0];
    r.mem   = nrn_membrane[DATA_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer requests from the pending queue, predict on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    tick_input_t t;
    logic        busy;
    busy = in_valid;
    if (rst_n && in_valid && !in_stall) begin
      t.exc   = in_exc_drive;
      t.inh   = in_inh_drive;
      t.noise = in_noise_sample;
      expected_ticks.push_back(neuron_tick(t));
      busy = 1'b0;
    end
    // hold a stalled request, otherwise load the next one or idle
    if (!busy) begin
      if (rst_n && pending_ticks.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        t = pending_ticks.pop_front();
        in_valid        <= 1'b1;
        in_exc_drive    <= t.exc;
        in_inh_drive    <= t.inh;
        in_noise_sample <= t.noise;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receive
    if (pressure_armed && !pressure_done && out_valid) begin
      pressure_done = 1'b1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    tick_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        $error("result with no request outstanding: fired=%0d rate=%0d mem=%0d",
               out_fired, $signed(out_rate_signal), $signed(out_membrane_out));
        errors = errors + 1;
      end else begin
        e = expected_ticks.pop_front();
        if (out_fired !== e.fired) begin
          $error("fired: expected %0d, got %0d", e.fired, out_fired);
          errors = errors + 1;
        end
        if (out_rate_signal !== e.rate) begin
          $error("rate_signal: expected %0d, got %0d", $signed(e.rate),
                 $signed(out_rate_signal));
          errors = errors + 1;
        end
        if (out_membrane_out !== e.mem) begin
          $error("membrane_out: expected %0d, got %0d", $signed(e.mem),
                 $signed(out_membrane_out));
          errors = errors + 1;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Write one register; the caller drops the write enable after the last one
  task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      IDX_MDECAY: cfg_mdecay = longint'(val[DECAY_W-1:0]);
      IDX_GAIN:   cfg_gain   = sx32(val);
      IDX_WEXC:   cfg_wexc   = sx32(val);
      IDX_BIAS:   cfg_bias   = sx32(val);
      IDX_ADECAY: cfg_adecay = longint'(val[DECAY_W-1:0]);
      IDX_ASTEP:  cfg_astep  = sx32(val);
      IDX_THR:    cfg_thr    = sx32(val);
      IDX_RDECAY: cfg_rdecay = longint'(val[DECAY_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait until every request has been taken and every result has come back
  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || expected_ticks.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  task automatic push_tick(logic [DATA_W-1:0] e, logic [DATA_W-1:0] i,
                           logic [DATA_W-1:0] n);
    tick_input_t t;
    t.exc   = e;
    t.inh   = i;
    t.noise = n;
    pending_ticks.push_back(t);
  endtask

  // Random decay word: random upper bits, which the block must drop
  function automatic logic [DATA_W-1:0] decay_word(int lo);
    return {16'($urandom), 16'($urandom_range(65535, lo))};
  endfunction

  // Wild settings span the whole range; plausible ones keep the neuron lively
  task automatic write_random_cfg(bit wild);
    if (wild) begin
      write_reg(IDX_MDECAY, $urandom);
      write_reg(IDX_GAIN,   $urandom);
      write_reg(IDX_WEXC,   $urandom);
      write_reg(IDX_BIAS,   $urandom);
      write_reg(IDX_ADECAY, $urandom);
      write_reg(IDX_ASTEP,  $urandom);
      write_reg(IDX_THR,    $urandom);
      write_reg(IDX_RDECAY, $urandom);
    end else begin
      write_reg(IDX_MDECAY, decay_word(40000));
      write_reg(IDX_GAIN,   $urandom_range(131072, 0));
      write_reg(IDX_WEXC,   $urandom_range(262144, 0));
      write_reg(IDX_BIAS,   $urandom_range(131072, 0) - 65536);
      write_reg(IDX_ADECAY, decay_word(40000));
      write_reg(IDX_ASTEP,  $urandom_range(524288, 0));
      write_reg(IDX_THR,    $urandom_range(131072, 0));
      write_reg(IDX_RDECAY, decay_word(40000));
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly physiological drive, the rest full-range noise
  task automatic push_random_tick();
    if ($urandom_range(99) < 25) begin
      push_tick($urandom, $urandom, $urandom);
    end else begin
      push_tick($urandom_range(262144, 0), -$urandom_range(131072, 0),
                $urandom_range(65536, 0) - 32768);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    cfg_mdecay = 62000;  cfg_gain  = 655;       cfg_wexc = 32768000; cfg_bias   = 0;
    cfg_adecay = 59300;  cfg_astep = 400031744; cfg_thr  = 11796;    cfg_rdecay = 63380;
    nrn_membrane = 0;  nrn_adaptation = 0;  nrn_rate = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 34;
    rcv_idle_pct = 47;

    // Directed, reset settings: field extremes and a steady drive that fires
    push_tick('0, '0, '0);
    push_tick(S32_MAX, '0, '0);
    push_tick(S32_MIN, '0, '0);
    push_tick('0, S32_MAX, '0);
    push_tick('0, S32_MIN, '0);
    push_tick('0, '0, S32_MAX);
    push_tick('0, '0, S32_MIN);
    push_tick(S32_MAX, S32_MAX, S32_MAX);
    push_tick(S32_MIN, S32_MIN, S32_MIN);
    for (int k = 0; k < 5; k++) push_tick(32'h0001_0000, '0, '0);
    drain();

    // Extreme settings: instant membrane, most negative adaptation step,
    // so membrane minus adaptation runs past the 32-bit range
    write_reg(IDX_MDECAY, 32'hFFFF_0000);
    write_reg(IDX_GAIN,   S32_MAX);
    write_reg(IDX_WEXC,   S32_MIN);
    write_reg(IDX_BIAS,   S32_MAX);
    write_reg(IDX_ADECAY, 32'hABCD_0000);
    write_reg(IDX_ASTEP,  S32_MIN);
    write_reg(IDX_THR,    S32_MAX);
    write_reg(IDX_RDECAY, 32'h1234_0000);
    cfg_we <= 1'b0;
    push_tick(S32_MIN, S32_MAX, S32_MAX);
    push_tick(S32_MIN, S32_MAX, S32_MAX);
    push_tick(S32_MAX, S32_MIN, S32_MIN);
    push_tick(32'hFFFF_FFFF, '0, '0);
    drain();

    // Opposite extremes: slowest decays, lowest threshold
    write_reg(IDX_MDECAY, 32'h0000_FFFF);
    write_reg(IDX_GAIN,   S32_MIN);
    write_reg(IDX_WEXC,   S32_MAX);
    write_reg(IDX_BIAS,   S32_MIN);
    write_reg(IDX_ADECAY, 32'hFFFF_FFFF);
    write_reg(IDX_ASTEP,  S32_MAX);
    write_reg(IDX_THR,    S32_MIN);
    write_reg(IDX_RDECAY, 32'h0000_FFFF);
    cfg_we <= 1'b0;
    push_tick(S32_MAX, '0, '0);
    push_tick(S32_MIN, S32_MIN, '0);
    push_tick('0, '0, '0);
    push_tick(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    push_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();

    // Random segments across the three idling profiles
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        snd_idle_pct = 47;
        rcv_idle_pct = 34;
      end else if (seg == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        pressure_armed = 1'b1;
      end
      write_random_cfg(seg == 1 || seg == 5);
      for (int k = 0; k < SEG_ITEMS; k++) push_random_tick();
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_ticks.size() != 0) begin
      $error("%0d predicted results never arrived", expected_ticks.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
